### rtl/gfls_pkg.sv
// Shared constants, types and GF(2^8) arithmetic for the secret recovery block.
package gfls_pkg;

	localparam int MAX_SHARES = 16;
	localparam int IDX_W      = (MAX_SHARES > 1) ? $clog2(MAX_SHARES) : 1;
	localparam int CNT_W      = $clog2(MAX_SHARES + 1);

	// a^254 by squaring: one plain square that sets the product to one, then seven square-and-multiply steps
	localparam int INV_STEPS  = 8;
	localparam int INV_SW     = $clog2(INV_STEPS);

	localparam logic [8:0] GF_POLY = 9'h11B;
	localparam logic [7:0] GF_ONE  = 8'h01;

	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_DUP = 2'd1;
	localparam logic [1:0] STAT_OVF = 2'd2;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_START,
		OP_LDJ,
		OP_ACM,
		OP_INV,
		OP_FIN1,
		OP_FIN2,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             we;
		logic [IDX_W-1:0] addr;
		logic             skip;
		logic             inv_first;
		logic             ovf;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

	// shift-and-add multiply, reduced by 0x11B
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] sh;
		logic [7:0] acc;
		acc = '0;
		sh  = {1'b0, a};
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc ^= sh[7:0];
			sh = {sh[7:0], 1'b0};
			if (sh[8]) sh ^= GF_POLY;
		end
		return acc;
	endfunction

endpackage

### rtl/gf256_lagrange_secret_recover.sv
// Top level: Shamir secret byte recovery over GF(2^8) by Lagrange interpolation at zero.
//
// Input channel (in_valid/in_ready): one beat per share point (point_x, point_y).
// Non-final beats are taken one a cycle and only stored. A beat with is_last set
// is stored as well, then starts recovery over all points held; in_ready stays
// low until the result has been placed in the output register.
// Store holds up to 16 points; a point offered beyond that is dropped and the
// result reports status 2 (too many points) with secret 0. Two equal x values
// give status 1 with secret 0. Either way the point set is emptied afterwards.
// Per point j the loop fetches point j, reads each point m on the store's
// single read port, inverts on the square-and-multiply pair and folds the
// term in; after the last point the result register is loaded. Overflow
// results skip the loop and go straight to the output state.
// Output channel (out_valid/out_ready): a registered beat of secret_byte and
// status. While the receiver stalls, new points are still taken; only a further
// final beat waits, holding its result until the register frees.
// Reset (arst_n low) empties the point set and drops any pending result.
module gf256_lagrange_secret_recover (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] point_x,
	input  logic [7:0] point_y,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] secret_byte,
	output logic [1:0] status
);

	gfls_pkg::dp_cmd_t  cmd;
	gfls_pkg::dp_stat_t stat;

	gfls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.is_last  (is_last),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gfls_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_x     (point_x),
		.point_y     (point_y),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.secret_byte (secret_byte),
		.status      (status)
	);

`ifndef SYNTHESIS
	// an error result never carries a secret
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != gfls_pkg::STAT_OK) |-> (secret_byte == 8'd0))
		else $error("error status with non-zero secret");

	// a final beat always starts recovery, blocking the input
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && is_last |=> !in_ready)
		else $error("input still open after final beat");

	// a fresh result only appears after a recovery that held the input off
	a_out_after_rec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without recovery");
`endif

endmodule

### rtl/gfls_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gfls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/gfls_ctrl.sv
// Sequencer: point loading, interpolation loop control and result hand-off.
module gfls_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               is_last,
	output logic               in_ready,
	input  gfls_pkg::dp_stat_t stat,
	output gfls_pkg::dp_cmd_t  cmd
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_RDJ  = 9'b000000010,
		S_LDJ  = 9'b000000100,
		S_RDM  = 9'b000001000,
		S_ACM  = 9'b000010000,
		S_INV  = 9'b000100000,
		S_FIN1 = 9'b001000000,
		S_FIN2 = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t                         state_q, state_d;
	logic [gfls_pkg::CNT_W-1:0]     count_q;
	logic                           ovf_q;
	logic [gfls_pkg::IDX_W-1:0]     j_q, m_q;
	logic [gfls_pkg::INV_SW-1:0]    k_q;
	logic                           full;
	logic                           last_m, last_j;
	logic                           accept;

	assign full     = (count_q == gfls_pkg::CNT_W'(gfls_pkg::MAX_SHARES));
	assign last_m   = ((gfls_pkg::CNT_W'(m_q) + gfls_pkg::CNT_W'(1)) == count_q);
	assign last_j   = ((gfls_pkg::CNT_W'(j_q) + gfls_pkg::CNT_W'(1)) == count_q);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.op        = gfls_pkg::OP_NONE;
		cmd.ovf       = ovf_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.addr = count_q[gfls_pkg::IDX_W-1:0];
				cmd.we   = in_valid && !full;
				if (in_valid && is_last) begin
					cmd.op  = gfls_pkg::OP_START;
					state_d = (ovf_q || full) ? S_OUT : S_RDJ;
				end
			end
			S_RDJ: begin
				cmd.addr = j_q;
				state_d  = S_LDJ;
			end
			S_LDJ: begin
				cmd.op  = gfls_pkg::OP_LDJ;
				state_d = S_RDM;
			end
			S_RDM: begin
				cmd.addr = m_q;
				state_d  = S_ACM;
			end
			S_ACM: begin
				cmd.op   = gfls_pkg::OP_ACM;
				cmd.skip = (m_q == j_q);
				state_d  = last_m ? S_INV : S_RDM;
			end
			S_INV: begin
				cmd.op        = gfls_pkg::OP_INV;
				cmd.inv_first = (k_q == '0);
				if (k_q == gfls_pkg::INV_SW'(gfls_pkg::INV_STEPS - 1)) state_d = S_FIN1;
			end
			S_FIN1: begin
				cmd.op  = gfls_pkg::OP_FIN1;
				state_d = S_FIN2;
			end
			S_FIN2: begin
				cmd.op  = gfls_pkg::OP_FIN2;
				state_d = last_j ? S_OUT : S_RDJ;
			end
			S_OUT: begin
				if (!stat.out_busy) begin
					cmd.op  = gfls_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			j_q     <= '0;
			m_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (!full) count_q <= count_q + gfls_pkg::CNT_W'(1);
				else       ovf_q   <= 1'b1;
				j_q <= '0;
			end
			if (state_q == S_LDJ) begin
				m_q <= '0;
				k_q <= '0;
			end
			if (state_q == S_ACM) m_q <= m_q + gfls_pkg::IDX_W'(1);
			if (state_q == S_INV) k_q <= k_q + gfls_pkg::INV_SW'(1);
			if (state_q == S_FIN2) j_q <= j_q + gfls_pkg::IDX_W'(1);
			if (cmd.op == gfls_pkg::OP_OUT) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

endmodule

### rtl/gfls_dp.sv
// Datapath: point store, field multipliers, inversion, accumulator, result register.
module gfls_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         point_x,
	input  logic [7:0]         point_y,
	input  gfls_pkg::dp_cmd_t  cmd,
	output gfls_pkg::dp_stat_t stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         secret_byte,
	output logic [1:0]         status
);

	logic [15:0] rdata;
	logic [7:0]  rx, ry;
	logic [7:0]  xj_q, yj_q, num_q, den_q, inv_q, acc_q;
	logic        dup_q;
	logic [7:0]  secret_q;
	logic [1:0]  status_q;
	logic        out_valid_q;

	gfls_ram #(
		.WIDTH(16),
		.DEPTH(gfls_pkg::MAX_SHARES)
	) u_store (
		.clk   (clk),
		.we    (cmd.we),
		.waddr (cmd.addr),
		.wdata ({point_x, point_y}),
		.raddr (cmd.addr),
		.rdata (rdata)
	);

	assign rx = rdata[15:8];
	assign ry = rdata[7:0];

	// arithmetic registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			gfls_pkg::OP_START: begin
				acc_q <= '0;
				dup_q <= 1'b0;
			end
			gfls_pkg::OP_LDJ: begin
				xj_q  <= rx;
				yj_q  <= ry;
				num_q <= gfls_pkg::GF_ONE;
				den_q <= gfls_pkg::GF_ONE;
			end
			gfls_pkg::OP_ACM: begin
				if (!cmd.skip) begin
					num_q <= gfls_pkg::gf_mul(num_q, rx);
					den_q <= gfls_pkg::gf_mul(den_q, rx ^ xj_q);
					if (rx == xj_q) dup_q <= 1'b1;
				end
			end
			gfls_pkg::OP_INV: begin
				// den walks a^2, a^4 .. ; inv collects a^2 .. a^128
				den_q <= gfls_pkg::gf_mul(den_q, den_q);
				inv_q <= cmd.inv_first ? gfls_pkg::GF_ONE : gfls_pkg::gf_mul(inv_q, den_q);
			end
			gfls_pkg::OP_FIN1: num_q <= gfls_pkg::gf_mul(num_q, inv_q);
			gfls_pkg::OP_FIN2: acc_q <= acc_q ^ gfls_pkg::gf_mul(yj_q, num_q);
			gfls_pkg::OP_OUT: begin
				if (cmd.ovf) begin
					status_q <= gfls_pkg::STAT_OVF;
					secret_q <= '0;
				end else if (dup_q) begin
					status_q <= gfls_pkg::STAT_DUP;
					secret_q <= '0;
				end else begin
					status_q <= gfls_pkg::STAT_OK;
					secret_q <= acc_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == gfls_pkg::OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign secret_byte   = secret_q;
	assign status        = status_q;

endmodule

### test/gf256_lagrange_secret_recover_test.sv
// Self-checking bench for GF(2^8) Shamir secret byte recovery by Lagrange interpolation at zero.
`timescale 1ns / 100ps

module gf256_lagrange_secret_recover_test;

	localparam int ITEM_TOTAL = 1550;
	// Once the last expected beat is in, wait longer than a full set of sixteen
	// points takes to recover.
	localparam int DRAIN_CYCLES = 720;

	typedef struct packed {
		logic [7:0] secret;
		logic [1:0] status;
	} recovery_t;

	// One row of the directed table. Rows marked typed carry the result by hand;
	// the others are left to the predictor.
	typedef struct {
		logic [7:0] x;
		logic [7:0] y;
		bit         last;
		bit         typed;
		recovery_t  want;
	} share_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] point_x = 8'h00;
	logic [7:0] point_y = 8'h00;
	logic       is_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] secret_byte;
	logic [1:0] status;

	// Predictor state: the bench's own copy of the point store.
	logic [7:0] held_x [gfls_pkg::MAX_SHARES];
	logic [7:0] held_y [gfls_pkg::MAX_SHARES];
	int         held_count = 0;
	bit         held_overflow = 1'b0;
	logic [7:0] recip [256];

	recovery_t  pending_results [$];
	share_row_t directed_rows [$];

	int items_sent = 0;
	int sets_sent = 0;
	int dup_sets = 0;
	int ovf_sets = 0;
	int results_checked = 0;
	int failures = 0;

	gf256_lagrange_secret_recover dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.is_last     (is_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.secret_byte (secret_byte),
		.status      (status)
	);

	always #10 clk = ~clk;

	// Horner-style product: double the accumulator (xtime) for each bit of b,
	// MSB first, adding a where the bit is set.
	function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 7; i >= 0; i--) begin
			acc = {acc[6:0], 1'b0} ^ (acc[7] ? gfls_pkg::GF_POLY[7:0] : 8'h00);
			if (b[i]) acc ^= a;
		end
		return acc;
	endfunction

	// Takes one accepted beat into the predictor's store. On a final beat it
	// returns 1 with the recovered byte and status, and empties the store.
	function automatic bit take_point(input logic [7:0] x, input logic [7:0] y,
			input bit last, output recovery_t res);
		logic [7:0] num;
		logic [7:0] den;
		logic [7:0] acc;
		bit dup;
		res = '{secret: 8'h00, status: gfls_pkg::STAT_OK};
		if (held_count < gfls_pkg::MAX_SHARES) begin
			held_x[held_count] = x;
			held_y[held_count] = y;
			held_count++;
		end else begin
			// store full: the point is dropped and the set is spoilt
			held_overflow = 1'b1;
		end
		if (!last)
			return 1'b0;
		dup = 1'b0;
		for (int j = 0; j < held_count; j++)
			for (int m = j + 1; m < held_count; m++)
				if (held_x[j] == held_x[m])
					dup = 1'b1;
		if (held_overflow) begin
			// overflow is reported in preference to duplicates
			res.status = gfls_pkg::STAT_OVF;
		end else if (dup) begin
			res.status = gfls_pkg::STAT_DUP;
		end else begin
			// basis polynomial at zero: prod x_m / prod (x_m ^ x_j), one inversion per term
			acc = 8'h00;
			for (int j = 0; j < held_count; j++) begin
				num = gfls_pkg::GF_ONE;
				den = gfls_pkg::GF_ONE;
				for (int m = 0; m < held_count; m++)
					if (m != j) begin
						num = gf_times(num, held_x[m]);
						den = gf_times(den, held_x[m] ^ held_x[j]);
					end
				acc ^= gf_times(held_y[j], gf_times(num, recip[den]));
			end
			res.secret = acc;
		end
		held_count = 0;
		held_overflow = 1'b0;
		return 1'b1;
	endfunction

	function automatic void add_row(input logic [7:0] x, input logic [7:0] y, input bit last,
			input bit typed, input logic [7:0] secret, input logic [1:0] stat);
		share_row_t row;
		row.x = x;
		row.y = y;
		row.last = last;
		row.typed = typed;
		row.want = '{secret: secret, status: stat};
		directed_rows.push_back(row);
	endfunction

	// Offers one point beat after a random gap (none in a burst) and holds it
	// steady until taken. On acceptance the predictor is updated and any result
	// it owes is queued; a typed row queues its hand-written result instead.
	task automatic send_point(input logic [7:0] x, input logic [7:0] y, input bit last,
			input bit typed, input recovery_t want, input bit burst);
		int gap;
		recovery_t res;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		is_last <= last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (take_point(x, y, last, res))
			pending_results.push_back(typed ? want : res);
	endtask

	// Stimulus: directed table first, then random share sets, then drain.
	initial begin
		logic [7:0] set_x [20];
		logic [7:0] cand;
		int n;
		int kind;
		int a;
		int b;
		bit fresh;
		bit burst;

		// reciprocal table by search; zero maps to zero
		recip[0] = 8'h00;
		for (int p = 1; p < 256; p++)
			for (int q = 1; q < 256; q++)
				if (gf_times(p[7:0], q[7:0]) == gfls_pkg::GF_ONE)
					recip[p] = q[7:0];

		// lone point at x = 0: its y is the secret
		add_row(8'h00, 8'hA5, 1'b1, 1'b1, 8'hA5, gfls_pkg::STAT_OK);
		// lone point at the top of the field with y = 0
		add_row(8'hFF, 8'h00, 1'b1, 1'b1, 8'h00, gfls_pkg::STAT_OK);
		// repeated x
		add_row(8'h01, 8'h12, 1'b0, 1'b0, 8'h00, gfls_pkg::STAT_OK);
		add_row(8'h01, 8'h34, 1'b1, 1'b1, 8'h00, gfls_pkg::STAT_DUP);
		// a pair containing x = 0 recovers that point's y
		add_row(8'h00, 8'h5A, 1'b0, 1'b0, 8'h00, gfls_pkg::STAT_OK);
		add_row(8'h9C, 8'h3E, 1'b1, 1'b1, 8'h5A, gfls_pkg::STAT_OK);
		// ordinary pair, left to the predictor
		add_row(8'h01, 8'h11, 1'b0, 1'b0, 8'h00, gfls_pkg::STAT_OK);
		add_row(8'h02, 8'h22, 1'b1, 1'b0, 8'h00, gfls_pkg::STAT_OK);
		// seventeen points: the last one finds the store full and is dropped
		for (int i = 1; i <= gfls_pkg::MAX_SHARES + 1; i++)
			add_row(i[7:0], ~i[7:0], i == gfls_pkg::MAX_SHARES + 1,
				i == gfls_pkg::MAX_SHARES + 1, 8'h00, gfls_pkg::STAT_OVF);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_point(directed_rows[r].x, directed_rows[r].y, directed_rows[r].last,
				directed_rows[r].typed, directed_rows[r].want, 1'b0);
		sets_sent = 6;
		dup_sets = 1;
		ovf_sets = 1;

		// Random share sets. Mostly small well-formed sets, a few large ones,
		// some with a repeated x and a few that overrun the store.
		while (items_sent < ITEM_TOTAL) begin
			kind = $urandom_range(0, 99);
			burst = ($urandom_range(0, 3) == 0);
			if (kind < 4) begin
				n = $urandom_range(gfls_pkg::MAX_SHARES + 1, 20);
				for (int i = 0; i < n; i++)
					set_x[i] = 8'($urandom_range(0, 255));
				ovf_sets++;
			end else begin
				if (kind < 12)
					n = $urandom_range(2, gfls_pkg::MAX_SHARES);
				else if (kind < 84)
					n = $urandom_range(1, 6);
				else
					n = $urandom_range(7, gfls_pkg::MAX_SHARES);
				for (int i = 0; i < n; i++) begin
					do begin
						cand = 8'($urandom_range(0, 255));
						fresh = 1'b1;
						for (int k = 0; k < i; k++)
							if (set_x[k] == cand)
								fresh = 1'b0;
					end while (!fresh);
					set_x[i] = cand;
				end
				if (kind < 12) begin
					a = $urandom_range(0, n - 1);
					b = (a + 1 + $urandom_range(0, n - 2)) % n;
					set_x[b] = set_x[a];
					dup_sets++;
				end
			end
			for (int i = 0; i < n; i++)
				send_point(set_x[i], 8'($urandom_range(0, 255)), i == n - 1, 1'b0,
					'{secret: 8'h00, status: gfls_pkg::STAT_OK}, burst);
			sets_sent++;
		end
		in_valid <= 1'b0;
		is_last <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		// anything arriving now is a stray beat and is flagged by the receiver
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d share beats in %0d sets (%0d with a repeated x, %0d %s).",
			items_sent, sets_sent, dup_sets, ovf_sets, "overrunning the store");
		$display("Checked %0d recovered bytes, %0d mismatches.", results_checked, failures);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Receiver: stalls a random number of cycles before each beat, with short
	// stall-free stretches, then checks the beat against the oldest expectation.
	initial begin
		int stall;
		bit burst;
		recovery_t want;
		burst = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (results_checked % 16 == 0)
				burst = ($urandom_range(0, 3) == 0);
			stall = burst ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			results_checked++;
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: secret_byte %02h status %0d",
					secret_byte, status);
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (secret_byte !== want.secret) begin
					$error("secret_byte: expected %02h, got %02h", want.secret, secret_byte);
					failures++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					failures++;
				end
			end
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#100_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
